### rtl/fiber_tracker_cluster_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cluster decoder
// Clocked concurrent assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef FIBER_TRACKER_CLUSTER_DECODER_TOP_MACROS_SVH
`define FIBER_TRACKER_CLUSTER_DECODER_TOP_MACROS_SVH

// Same-cycle implication
`define FTCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define FTCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ftcd_pkg.sv
// ----------------------------------------------------------------------------
// ftcd_pkg
// Shared types, codes and constants of the fiber tracker cluster decoder.
// ----------------------------------------------------------------------------
package ftcd_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_CLUSTER   = 2'd0;
  localparam logic [1:0] STATUS_OVERRUN   = 2'd1;
  localparam logic [1:0] STATUS_NO_MODULE = 2'd2;
  localparam logic [1:0] STATUS_CORRUPT   = 2'd3;

  // Pseudo sizes of plain results
  localparam logic [4:0] SIZE_FRAGMENT = 5'd0;
  localparam logic [4:0] SIZE_NORMAL   = 5'd4;

  // Highest module number that exists
  localparam logic [7:0] MAX_MODULE = 8'd5;

  // Register map: index is byte address bit 2
  localparam int unsigned ADDR_W = 3;
  localparam logic REG_DECODE_MODE = 1'b0;
  localparam logic REG_MAX_WIDTH   = 1'b1;

  localparam logic       DECODE_MODE_RST = 1'b1;
  localparam logic [3:0] MAX_WIDTH_RST   = 4'd4;
  localparam logic [3:0] WIDTH_MIN       = 4'd3;
  localparam logic [3:0] WIDTH_MAX       = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EMIT
  } ctrl_state_e;

  // Configuration seen by the datapath (width already saturated)
  typedef struct packed {
    logic       mode;
    logic [3:0] width;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_last;
    logic out_busy;
  } dp_status_t;

endpackage

### rtl/ftcd_in_if.sv
// ----------------------------------------------------------------------------
// ftcd_in_if
// Input channel: one bank word with its bank context per transaction.
// ----------------------------------------------------------------------------
interface ftcd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] word;
  logic [5:0]  source_id;
  logic        start_of_bank;
  logic [11:0] words_left;

  modport source (
    output valid, word, source_id, start_of_bank, words_left,
    input  ready
  );

  modport sink (
    input  valid, word, source_id, start_of_bank, words_left,
    output ready
  );
endinterface

### rtl/ftcd_out_if.sv
// ----------------------------------------------------------------------------
// ftcd_out_if
// Result channel: one decoded cluster or status record per transaction.
// ----------------------------------------------------------------------------
interface ftcd_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        station;
  logic [1:0]        layer;
  logic [1:0]        quarter;
  logic [3:0]        module_res;
  logic [1:0]        mat;
  logic [1:0]        detector;
  logic signed [7:0] channel;
  logic              fraction;
  logic [4:0]        pseudo_size;
  logic [1:0]        status;
  logic              last_result;

  modport source (
    output valid, station, layer, quarter, module_res, mat, detector,
           channel, fraction, pseudo_size, status, last_result,
    input  ready
  );

  modport sink (
    input  valid, station, layer, quarter, module_res, mat, detector,
           channel, fraction, pseudo_size, status, last_result,
    output ready
  );
endinterface

### rtl/fiber_tracker_cluster_decoder_top.sv
// ----------------------------------------------------------------------------
// fiber_tracker_cluster_decoder_top
// Readout bank word decoder producing cluster and status records.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one bank word per transaction with its source id, a bank
//   start flag and the count of words left in the bank. out_o carries the
//   decoded records; last_result marks the final record of one word.
//   Registers on the APB port: decode mode at 0x0, max cluster width at 0x4.
// Timing:
//   A word is taken, decoded once the output register is free, and its first
//   record is registered onto out_o by the decode step. A fragmented span
//   gives one record per cycle while out_o is not stalled, up to 44, set by
//   the span stepping adder that walks the middle clusters. Words that give
//   no record (headers, held clusters, skipped modules) still pass the decode
//   state. The next word is taken while the last record of a word still waits.
// Reset:
//   Mode v3 with width 4; the parser expects a header. No clearing pass.
// Stall:
//   A stalled receiver holds the record on out_o; in_i ready drops once a
//   word is captured until its records can go out.
// ----------------------------------------------------------------------------
module fiber_tracker_cluster_decoder_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ftcd_in_if.sink                     in_i,
  ftcd_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ftcd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  ftcd_pkg::cfg_t       cfg;
  ftcd_pkg::dp_cmd_t    cmd;
  ftcd_pkg::dp_status_t status;
  logic                 in_ready;

  assign in_i.ready = in_ready;

  ftcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ftcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ftcd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .status_o        (status),
    .word_i          (in_i.word),
    .source_id_i     (in_i.source_id),
    .start_of_bank_i (in_i.start_of_bank),
    .words_left_i    (in_i.words_left),
    .out_o           (out_o)
  );

endmodule

### rtl/ftcd_regs.sv
// ----------------------------------------------------------------------------
// ftcd_regs
// APB configuration registers: decode mode and maximum cluster width.
// ----------------------------------------------------------------------------
module ftcd_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ftcd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output ftcd_pkg::cfg_t            cfg_o
);

  logic       mode_q;
  logic [3:0] width_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ftcd_pkg::DECODE_MODE_RST;
      width_q <= ftcd_pkg::MAX_WIDTH_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        ftcd_pkg::REG_DECODE_MODE: mode_q  <= pwdata[0];
        ftcd_pkg::REG_MAX_WIDTH:   width_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      ftcd_pkg::REG_DECODE_MODE: prdata = {31'b0, mode_q};
      ftcd_pkg::REG_MAX_WIDTH:   prdata = {28'b0, width_q};
      default:                   prdata = '0;
    endcase
  end

  // Saturate width to its legal range
  always_comb begin
    cfg_o.mode = mode_q;
    if (width_q < ftcd_pkg::WIDTH_MIN) begin
      cfg_o.width = ftcd_pkg::WIDTH_MIN;
    end else if (width_q > ftcd_pkg::WIDTH_MAX) begin
      cfg_o.width = ftcd_pkg::WIDTH_MAX;
    end else begin
      cfg_o.width = width_q;
    end
  end

endmodule

### rtl/ftcd_ctrl.sv
// ----------------------------------------------------------------------------
// ftcd_ctrl
// Sequencer: capture a word, decode it, then step through its results.
// ----------------------------------------------------------------------------
module ftcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ftcd_pkg::dp_status_t status_i,
  output ftcd_pkg::dp_cmd_t    cmd_o
);

  ftcd_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ftcd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ftcd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ftcd_pkg::ST_DECODE;
        end
      end
      ftcd_pkg::ST_DECODE: begin
        // hold while the previous result still blocks the output register
        if (!status_i.out_busy) begin
          cmd_o.decode = 1'b1;
          state_d      = status_i.has_result ? ftcd_pkg::ST_EMIT : ftcd_pkg::ST_IDLE;
        end
      end
      ftcd_pkg::ST_EMIT: begin
        if (status_i.out_last) begin
          // last result waits in the output register: take the next word
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.capture = 1'b1;
            state_d       = ftcd_pkg::ST_DECODE;
          end else if (!status_i.out_busy) begin
            state_d = ftcd_pkg::ST_IDLE;
          end
        end else if (!status_i.out_busy) begin
          cmd_o.advance = 1'b1;
        end
      end
      default: state_d = ftcd_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/ftcd_dpath.sv
// ----------------------------------------------------------------------------
// ftcd_dpath
// Parser state, word decode, fragment merge and span stepping, result register.
// ----------------------------------------------------------------------------
module ftcd_dpath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ftcd_pkg::cfg_t       cfg_i,
  input  ftcd_pkg::dp_cmd_t    cmd_i,
  output ftcd_pkg::dp_status_t status_o,
  input  logic [15:0]          word_i,
  input  logic [5:0]           source_id_i,
  input  logic                 start_of_bank_i,
  input  logic [11:0]          words_left_i,
  ftcd_out_if.source           out_o
);

  // captured input
  logic [15:0] word_q;
  logic [5:0]  src_q;
  logic        sob_q;
  logic [11:0] wl_q;

  // parser state
  logic [3:0]  cl_q, cl_d;
  logic [11:0] hf_q, hf_d;
  logic        skip_q, skip_d;
  logic        pv_q, pv_d;
  logic        disc_q, disc_d;
  logic [8:0]  pw_q, pw_d;

  // result register
  logic              ov_q;
  logic              last_q;
  logic [2:0]        station_q;
  logic [1:0]        layer_q;
  logic [1:0]        quarter_q;
  logic [3:0]        mod_q;
  logic [1:0]        mat_q;
  logic [1:0]        det_q;
  logic signed [7:0] ch_q;
  logic              frac_q;
  logic [4:0]        size_q;
  logic [1:0]        stat_q;

  // queued results: span middles, then one final result
  logic       mid_act_q;
  logic [7:0] mid_ch_q;
  logic       mid_f_q;
  logic [6:0] fin_ch_q;
  logic       fin_f_q;
  logic [4:0] fin_size_q;
  logic [3:0] step_q;

  // decode outputs
  logic              res_first;
  logic signed [7:0] f_ch;
  logic              f_frac;
  logic [4:0]        f_size;
  logic [1:0]        f_stat;
  logic [3:0]        f_mod;
  logic [1:0]        f_mat;
  logic [1:0]        f_det;
  logic              q_second;
  logic              q_span;
  logic [4:0]        q_fin_size;

  logic [3:0]  cur_cl, cln;
  logic        cur_skip, cur_pv, cur_disc;
  logic [6:0]  c1, c2, diff;
  logic        f1, f2;
  logic [3:0]  m_minus1;
  logic [8:0]  merge_ch;
  logic [4:0]  wid;
  logic [7:0]  q_mid_ch;
  logic        mid_more;

  assign c1       = pw_q[6:0];
  assign f1       = pw_q[7];
  assign c2       = word_q[6:0];
  assign f2       = word_q[7];
  assign diff     = c2 - c1;
  assign m_minus1 = cfg_i.width - 4'd1;
  assign merge_ch = {2'b0, c1} + {2'b0, diff} - 9'd1 - {6'b0, m_minus1[3:1]};
  assign wid      = {diff[3:0], 1'b0} - 5'd1 + {4'b0, f2};
  assign q_mid_ch = {1'b0, c1} + {4'b0, cfg_i.width};

  // bank start clears the parser before the word is looked at
  assign cur_cl   = sob_q ? 4'd0 : cl_q;
  assign cur_skip = sob_q ? 1'b0 : skip_q;
  assign cur_pv   = sob_q ? 1'b0 : pv_q;
  assign cur_disc = sob_q ? 1'b0 : disc_q;
  assign cln      = cur_cl - 4'd1;

  always_comb begin
    cl_d       = cur_cl;
    hf_d       = hf_q;
    skip_d     = cur_skip;
    pv_d       = cur_pv;
    disc_d     = cur_disc;
    pw_d       = pw_q;
    res_first  = 1'b0;
    f_ch       = '0;
    f_frac     = 1'b0;
    f_size     = ftcd_pkg::SIZE_FRAGMENT;
    f_stat     = ftcd_pkg::STATUS_CLUSTER;
    f_mod      = hf_q[11:8];
    f_mat      = hf_q[7:6];
    f_det      = hf_q[5:4];
    q_second   = 1'b0;
    q_span     = 1'b0;
    q_fin_size = ftcd_pkg::SIZE_NORMAL;
    if (!cur_disc) begin
      if (cur_cl == 4'd0) begin
        if (wl_q == 12'd0 && word_q == 16'd0) begin
          // drop trailing padding
        end else if ({8'b0, word_q[3:0]} > wl_q) begin
          res_first = 1'b1;
          f_stat    = ftcd_pkg::STATUS_OVERRUN;
          f_mod     = word_q[11:8];
          f_mat     = word_q[7:6];
          f_det     = word_q[5:4];
          disc_d    = 1'b1;
          cl_d      = 4'd0;
          skip_d    = 1'b0;
          pv_d      = 1'b0;
        end else if (word_q[15:8] > ftcd_pkg::MAX_MODULE) begin
          res_first = 1'b1;
          f_stat    = ftcd_pkg::STATUS_NO_MODULE;
          f_mod     = word_q[11:8];
          f_mat     = word_q[7:6];
          f_det     = word_q[5:4];
          cl_d      = word_q[3:0];
          skip_d    = (word_q[3:0] != 4'd0);
        end else begin
          hf_d = word_q[11:0];
          cl_d = word_q[3:0];
        end
      end else begin
        cl_d = cln;
        if (cur_skip) begin
          if (cln == 4'd0) begin
            skip_d = 1'b0;
          end
        end else if (!cfg_i.mode) begin
          res_first = 1'b1;
          if (cur_pv) begin
            pv_d       = 1'b0;
            f_ch       = {1'b0, c1};
            f_frac     = f1;
            f_size     = ftcd_pkg::SIZE_NORMAL;
            q_second   = 1'b1;
            q_fin_size = word_q[8] ? ftcd_pkg::SIZE_FRAGMENT : ftcd_pkg::SIZE_NORMAL;
          end else begin
            f_ch   = {1'b0, c2};
            f_frac = f2;
            f_size = word_q[8] ? ftcd_pkg::SIZE_FRAGMENT : ftcd_pkg::SIZE_NORMAL;
          end
        end else if (cur_pv) begin
          pv_d      = 1'b0;
          res_first = 1'b1;
          if (word_q[8]) begin
            if (c2 < c1) begin
              f_ch   = {1'b0, c1};
              f_frac = f1;
              f_stat = ftcd_pkg::STATUS_CORRUPT;
              disc_d = 1'b1;
              cl_d   = 4'd0;
              skip_d = 1'b0;
            end else if (c2 == c1) begin
              f_ch   = {1'b0, c1};
              f_frac = f1;
              f_stat = ftcd_pkg::STATUS_CORRUPT;
            end else if (diff > {3'b0, cfg_i.width}) begin
              // long span: left edge now, middles and right edge queued
              f_ch       = {1'b0, c1};
              f_frac     = f1;
              q_second   = 1'b1;
              q_span     = 1'b1;
              q_fin_size = ftcd_pkg::SIZE_FRAGMENT;
            end else begin
              f_ch   = merge_ch[7:0];
              f_frac = f2;
              f_size = wid;
            end
          end else begin
            f_ch   = {1'b0, c1};
            f_frac = f1;
            f_size = ftcd_pkg::SIZE_NORMAL;
            if (cln != 4'd0) begin
              pv_d = 1'b1;
              pw_d = word_q[8:0];
            end else begin
              q_second = 1'b1;
            end
          end
        end else begin
          if (!word_q[8] && cln != 4'd0) begin
            pv_d = 1'b1;
            pw_d = word_q[8:0];
          end else begin
            res_first = 1'b1;
            f_ch      = {1'b0, c2};
            f_frac    = f2;
            f_size    = ftcd_pkg::SIZE_NORMAL;
          end
        end
      end
    end
  end

  assign mid_more = mid_act_q && (mid_ch_q < {1'b0, fin_ch_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      word_q <= word_i;
      src_q  <= source_id_i;
      sob_q  <= start_of_bank_i;
      wl_q   <= words_left_i;
    end
    if (cmd_i.decode) begin
      pw_q <= pw_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_q   <= '0;
      hf_q   <= '0;
      skip_q <= 1'b0;
      pv_q   <= 1'b0;
      disc_q <= 1'b0;
    end else if (cmd_i.decode) begin
      cl_q   <= cl_d;
      hf_q   <= hf_d;
      skip_q <= skip_d;
      pv_q   <= pv_d;
      disc_q <= disc_d;
    end
  end

  // result valid, last flag and span activity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q      <= 1'b0;
      last_q    <= 1'b0;
      mid_act_q <= 1'b0;
    end else if (cmd_i.decode && res_first) begin
      ov_q      <= 1'b1;
      last_q    <= !q_second;
      mid_act_q <= q_span;
    end else if (cmd_i.advance) begin
      last_q <= !mid_more;
      if (!mid_more) begin
        mid_act_q <= 1'b0;
      end
    end else if (ov_q && out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  // result payload and queued results
  always_ff @(posedge clk_i) begin
    if (cmd_i.decode && res_first) begin
      station_q  <= {1'b0, src_q[5:4]} + 3'd1;
      layer_q    <= src_q[3:2];
      quarter_q  <= src_q[1:0];
      mod_q      <= f_mod;
      mat_q      <= f_mat;
      det_q      <= f_det;
      ch_q       <= f_ch;
      frac_q     <= f_frac;
      size_q     <= f_size;
      stat_q     <= f_stat;
      mid_ch_q   <= q_mid_ch;
      mid_f_q    <= f1;
      fin_ch_q   <= c2;
      fin_f_q    <= f2;
      fin_size_q <= q_fin_size;
      step_q     <= cfg_i.width;
    end else if (cmd_i.advance) begin
      stat_q <= ftcd_pkg::STATUS_CLUSTER;
      if (mid_more) begin
        ch_q     <= mid_ch_q;
        frac_q   <= mid_f_q;
        size_q   <= ftcd_pkg::SIZE_FRAGMENT;
        mid_ch_q <= mid_ch_q + {4'b0, step_q};
      end else begin
        ch_q   <= {1'b0, fin_ch_q};
        frac_q <= fin_f_q;
        size_q <= fin_size_q;
      end
    end
  end

  assign status_o.has_result = res_first;
  assign status_o.out_last   = last_q;
  assign status_o.out_busy   = ov_q && !out_o.ready;

  assign out_o.valid       = ov_q;
  assign out_o.station     = station_q;
  assign out_o.layer       = layer_q;
  assign out_o.quarter     = quarter_q;
  assign out_o.module_res  = mod_q;
  assign out_o.mat         = mat_q;
  assign out_o.detector    = det_q;
  assign out_o.channel     = ch_q;
  assign out_o.fraction    = frac_q;
  assign out_o.pseudo_size = size_q;
  assign out_o.status      = stat_q;
  assign out_o.last_result = last_q;

endmodule

### rtl/ftcd_checker.sv
// ----------------------------------------------------------------------------
// ftcd_checker
// Port-level assertions on the decoder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "fiber_tracker_cluster_decoder_top_macros.svh"

module ftcd_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic             out_last_i,
  input logic [1:0]       out_status_i,
  input logic [4:0]       out_size_i,
  input logic signed [7:0] out_channel_i
);

  // a captured word is decoded before another transaction is taken
  `FTCD_ASSERT_NEXT(a_no_back_to_back_in, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input taken in decode cycle")

  // no word is taken while further records of the current word remain
  `FTCD_ASSERT_NOW(a_hold_in_mid_word, clk_i, rst_ni, out_valid_i && !out_last_i, !in_ready_i, "input taken before last record")

  // status records stand alone and carry no size
  `FTCD_ASSERT_NOW(a_status_single, clk_i, rst_ni, out_valid_i && (out_status_i != ftcd_pkg::STATUS_CLUSTER), out_last_i && (out_size_i == ftcd_pkg::SIZE_FRAGMENT), "status record malformed")

  // a stalled record holds
  `FTCD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_channel_i) && $stable(out_size_i) && $stable(out_status_i) && $stable(out_last_i), "stalled record changed")

endmodule

bind fiber_tracker_cluster_decoder_top ftcd_checker u_ftcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_last_i    (out_o.last_result),
  .out_status_i  (out_o.status),
  .out_size_i    (out_o.pseudo_size),
  .out_channel_i (out_o.channel)
);

### tb/fiber_tracker_cluster_decoder_checker.sv
// ----------------------------------------------------------------------------
// fiber_tracker_cluster_decoder_checker
// Watches the word and record channels and the register port, decodes every
// accepted word into the records it must produce, and compares each record
// the block hands out against the oldest one still owed.
// ----------------------------------------------------------------------------
module fiber_tracker_cluster_decoder_checker
  import ftcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  ftcd_in_if                word_ch_i,
  ftcd_out_if               rec_ch_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       recs_due_o,
  output int unsigned       fail_count_o
);

  typedef struct packed {
    logic [2:0]        station;
    logic [1:0]        layer;
    logic [1:0]        quarter;
    logic [3:0]        module_res;
    logic [1:0]        mat;
    logic [1:0]        detector;
    logic signed [7:0] channel;
    logic              fraction;
    logic [4:0]        pseudo_size;
    logic [1:0]        status;
    logic              last_result;
  } cluster_rec_t;

  // Register copies
  logic       merge_on;
  logic [3:0] span_width;

  // Parser state
  logic [3:0]  words_owed;
  logic [11:0] hdr_bits;
  logic        skipping;
  logic        held_ok;
  logic [8:0]  held_word;
  logic        in_discard;
  logic [5:0]  cur_src;

  cluster_rec_t word_recs[$];
  cluster_rec_t clusters_due[$];
  int unsigned  fails;

  function automatic void record_raw(logic [7:0] mod, logic [1:0] mat, logic [1:0] det,
                                     int chan, logic frac, logic [4:0] size, logic [1:0] st);
    cluster_rec_t r;
    r.station     = 3'(cur_src[5:4]) + 3'd1;
    r.layer       = cur_src[3:2];
    r.quarter     = cur_src[1:0];
    r.module_res  = mod[3:0];
    r.mat         = mat;
    r.detector    = det;
    r.channel     = 8'(chan);
    r.fraction    = frac;
    r.pseudo_size = size;
    r.status      = st;
    r.last_result = 1'b0;
    word_recs.push_back(r);
  endfunction

  function automatic void record(int chan, logic frac, logic [4:0] size, logic [1:0] st);
    record_raw({4'd0, hdr_bits[11:8]}, hdr_bits[7:6], hdr_bits[5:4], chan, frac, size, st);
  endfunction

  function automatic void enter_discard();
    in_discard = 1'b1;
    words_owed = '0;
    skipping   = 1'b0;
    held_ok    = 1'b0;
  endfunction

  function automatic void join_fragments(logic [8:0] lead, logic [15:0] tail);
    int   c1, c2, m, diff, wid, i;
    logic f1, f2;
    c1 = lead[6:0];
    f1 = lead[7];
    c2 = tail[6:0];
    f2 = tail[7];
    m  = span_width;
    if (m < WIDTH_MIN) m = WIDTH_MIN;
    if (m > WIDTH_MAX) m = WIDTH_MAX;
    if (c2 < c1) begin
      record(c1, f1, SIZE_FRAGMENT, STATUS_CORRUPT);
      enter_discard();
    end else if (c2 == c1) begin
      record(c1, f1, SIZE_FRAGMENT, STATUS_CORRUPT);
    end else begin
      diff = c2 - c1;
      if (diff > m) begin
        // edge, middles every m channels, far edge
        record(c1, f1, SIZE_FRAGMENT, STATUS_CLUSTER);
        for (i = m; i < diff; i += m) record(c1 + i, f1, SIZE_FRAGMENT, STATUS_CLUSTER);
        record(c2, f2, SIZE_FRAGMENT, STATUS_CLUSTER);
      end else begin
        wid = 2 * diff - 1 + int'(f2);
        record(c1 - (m - 1) / 2 + (wid - 1) / 2, 1'((wid - 1) & 1), 5'(wid),
               STATUS_CLUSTER);
      end
    end
  endfunction

  function automatic void take_single(logic [15:0] w);
    if (!w[8] && words_owed != 0) begin
      held_word = w[8:0];
      held_ok   = 1'b1;
    end else begin
      record(w[6:0], w[7], SIZE_NORMAL, STATUS_CLUSTER);
    end
  endfunction

  function automatic void decode_word(logic [15:0] w, logic [5:0] src, logic sob,
                                      logic [11:0] left);
    logic [7:0]   mod;
    logic [3:0]   cnt;
    cluster_rec_t r;
    word_recs.delete();
    cur_src = src;
    if (sob) begin
      words_owed = '0;
      skipping   = 1'b0;
      held_ok    = 1'b0;
      in_discard = 1'b0;
    end
    if (!in_discard) begin
      if (words_owed == 0) begin
        mod = w[15:8];
        cnt = w[3:0];
        // trailing zero padding gives nothing
        if (!(left == 0 && w == 16'h0000)) begin
          if (12'(cnt) > left) begin
            record_raw(mod, w[7:6], w[5:4], 0, 1'b0, SIZE_FRAGMENT, STATUS_OVERRUN);
            enter_discard();
          end else if (mod > MAX_MODULE) begin
            record_raw(mod, w[7:6], w[5:4], 0, 1'b0, SIZE_FRAGMENT, STATUS_NO_MODULE);
            words_owed = cnt;
            skipping   = (cnt != 0);
          end else begin
            hdr_bits   = w[11:0];
            words_owed = cnt;
          end
        end
      end else begin
        words_owed = words_owed - 4'd1;
        if (skipping) begin
          if (words_owed == 0) skipping = 1'b0;
        end else if (!merge_on) begin
          // flush a cluster held over from merging mode
          if (held_ok) begin
            held_ok = 1'b0;
            record(held_word[6:0], held_word[7], SIZE_NORMAL, STATUS_CLUSTER);
          end
          record(w[6:0], w[7], w[8] ? SIZE_FRAGMENT : SIZE_NORMAL, STATUS_CLUSTER);
        end else if (held_ok) begin
          held_ok = 1'b0;
          if (w[8]) begin
            join_fragments(held_word, w);
          end else begin
            record(held_word[6:0], held_word[7], SIZE_NORMAL, STATUS_CLUSTER);
            take_single(w);
          end
        end else begin
          take_single(w);
        end
      end
    end
    if (word_recs.size() > 0) begin
      r = word_recs.pop_back();
      r.last_result = 1'b1;
      word_recs.push_back(r);
    end
    foreach (word_recs[i]) clusters_due.push_back(word_recs[i]);
  endfunction

  function automatic int unsigned field_bad(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  function automatic void check_record();
    cluster_rec_t want;
    cluster_rec_t got;
    got.station     = rec_ch_i.station;
    got.layer       = rec_ch_i.layer;
    got.quarter     = rec_ch_i.quarter;
    got.module_res  = rec_ch_i.module_res;
    got.mat         = rec_ch_i.mat;
    got.detector    = rec_ch_i.detector;
    got.channel     = rec_ch_i.channel;
    got.fraction    = rec_ch_i.fraction;
    got.pseudo_size = rec_ch_i.pseudo_size;
    got.status      = rec_ch_i.status;
    got.last_result = rec_ch_i.last_result;
    if (clusters_due.size() == 0) begin
      $error("record transaction with no record owed (channel %0d, status %0d)",
             got.channel, got.status);
      fails++;
    end else begin
      want = clusters_due.pop_front();
      fails += field_bad("station", want.station, got.station);
      fails += field_bad("layer", want.layer, got.layer);
      fails += field_bad("quarter", want.quarter, got.quarter);
      fails += field_bad("module_res", want.module_res, got.module_res);
      fails += field_bad("mat", want.mat, got.mat);
      fails += field_bad("detector", want.detector, got.detector);
      fails += field_bad("channel", want.channel, got.channel);
      fails += field_bad("fraction", want.fraction, got.fraction);
      fails += field_bad("pseudo_size", want.pseudo_size, got.pseudo_size);
      fails += field_bad("status", want.status, got.status);
      fails += field_bad("last_result", want.last_result, got.last_result);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_on     = DECODE_MODE_RST;
      span_width   = MAX_WIDTH_RST;
      words_owed   = '0;
      hdr_bits     = '0;
      skipping     = 1'b0;
      held_ok      = 1'b0;
      held_word    = '0;
      in_discard   = 1'b0;
      cur_src      = '0;
      fails        = 0;
      clusters_due.delete();
      recs_due_o   <= 0;
      fail_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DECODE_MODE) merge_on = pwdata[0];
        else if (paddr[2] == REG_MAX_WIDTH) span_width = pwdata[3:0];
      end
      if (word_ch_i.valid && word_ch_i.ready) begin
        decode_word(word_ch_i.word, word_ch_i.source_id, word_ch_i.start_of_bank,
                    word_ch_i.words_left);
      end
      if (rec_ch_i.valid && rec_ch_i.ready) check_record();
      recs_due_o   <= clusters_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

### tb/fiber_tracker_cluster_decoder_top_test.sv
// ----------------------------------------------------------------------------
// fiber_tracker_cluster_decoder_top_test
// Drives readout banks into the cluster decoder: a directed opening on the
// corner cases, then random banks under several register settings with
// random stalls on both channels. The checker beside the block predicts
// and compares every record; this module gives the verdict.
// ----------------------------------------------------------------------------
module fiber_tracker_cluster_decoder_top_test;
  import ftcd_pkg::*;

  typedef struct packed {
    logic [15:0] word;
    logic [5:0]  source_id;
    logic        start_of_bank;
    logic [11:0] words_left;
  } bank_word_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned recs_due;
  int unsigned mismatch_total;
  int unsigned words_taken = 0;

  bit quiet          = 1'b0;
  int send_gap_pct   = 0;
  int sink_stall_pct = 0;

  bank_word_t  plan_q[$];
  logic [15:0] bank_body[$];

  bit       phase_merge [7] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
  bit [3:0] phase_width [7] = '{4'd8, 4'd3, 4'd8, 4'd0, 4'd15, 4'd15, 4'd5};

  ftcd_in_if  word_ch ();
  ftcd_out_if rec_ch ();

  fiber_tracker_cluster_decoder_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (word_ch),
    .out_o   (rec_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fiber_tracker_cluster_decoder_checker checker_u (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_ch_i    (word_ch),
    .rec_ch_i     (rec_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .recs_due_o   (recs_due),
    .fail_count_o (mismatch_total)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #9_600_000;
    $display("end of test: mismatches");
    $finish;
  end

  always @(posedge clk_i) begin
    if (word_ch.valid && word_ch.ready) words_taken <= words_taken + 1;
  end

  // Result side: random stall bursts, and once a long hold-off
  initial begin : sink_side
    int  stall_left;
    bit  held_off;
    stall_left = 0;
    held_off   = 1'b0;
    rec_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!held_off && words_taken >= 100) begin
        held_off = 1'b1;
        rec_ch.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      if (stall_left > 0) begin
        stall_left--;
        rec_ch.ready <= 1'b0;
      end else if (!quiet && sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = $urandom_range(0, 9);
        rec_ch.ready <= 1'b0;
      end else begin
        rec_ch.ready <= 1'b1;
      end
    end
  end

  function automatic void add_word(logic [15:0] w, logic [5:0] src, logic sob,
                                   logic [11:0] left);
    plan_q.push_back('{w, src, sob, left});
  endfunction

  function automatic logic [15:0] cluster_word(logic size_flag, logic frac, int chan);
    return {7'($urandom), size_flag, frac, 7'(chan)};
  endfunction

  function automatic void fill_clusters(int n);
    int c1, c2, roll;
    while (n > 0) begin
      roll = $urandom_range(0, 9);
      if (n >= 2 && roll < 5) begin
        c1   = $urandom_range(0, 127);
        roll = $urandom_range(0, 19);
        if (roll == 0 && c1 > 0) c2 = $urandom_range(0, c1 - 1);
        else if (roll == 1) c2 = c1;
        else if (roll < 5) c2 = c1 + $urandom_range(9, 127);
        else c2 = c1 + $urandom_range(1, 8);
        if (c2 > 127) c2 = 127;
        bank_body.push_back(cluster_word(1'b0, 1'($urandom), c1));
        bank_body.push_back(cluster_word(1'b1, 1'($urandom), c2));
        n -= 2;
      end else begin
        bank_body.push_back(cluster_word(1'($urandom_range(0, 3) == 0), 1'($urandom),
                                         $urandom_range(0, 127)));
        n--;
      end
    end
  endfunction

  function automatic void add_bank();
    logic [5:0] src;
    logic [7:0] mod;
    int         n_mod, cnt, m;
    bit         overrun;
    bank_body.delete();
    src     = 6'($urandom);
    n_mod   = $urandom_range(1, 3);
    overrun = ($urandom_range(0, 11) == 0);
    for (m = 0; m < n_mod; m++) begin
      mod = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(6, 255)) : 8'($urandom_range(0, 5));
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 6);
      if (overrun && m == n_mod - 1 && cnt == 0) cnt = 1;
      bank_body.push_back({mod, 2'($urandom), 2'($urandom), 4'(cnt)});
      // short the last module so its count runs past the bank end
      fill_clusters((overrun && m == n_mod - 1) ? $urandom_range(0, cnt - 1) : cnt);
    end
    if (!overrun && $urandom_range(0, 2) == 0) bank_body.push_back(16'h0000);
    foreach (bank_body[i]) begin
      add_word(bank_body[i], src, i == 0, 12'(bank_body.size() - 1 - i));
    end
  endfunction

  function automatic void add_noise();
    int k;
    for (k = $urandom_range(1, 3); k > 0; k--) begin
      add_word(16'($urandom), 6'($urandom), 1'($urandom), 12'($urandom));
    end
  endfunction

  task automatic reg_write(input logic idx, input logic [3:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_plan();
    bank_word_t it;
    while (plan_q.size() > 0) begin
      it = plan_q.pop_front();
      if (!quiet && send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
        word_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      word_ch.valid         <= 1'b1;
      word_ch.word          <= it.word;
      word_ch.source_id     <= it.source_id;
      word_ch.start_of_bank <= it.start_of_bank;
      word_ch.words_left    <= it.words_left;
      @(posedge clk_i);
      while (!word_ch.ready) @(posedge clk_i);
    end
  endtask

  // Hold until every owed record is out, then let stray work finish
  task automatic settle();
    word_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (recs_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [15:0] frag_demo [12] = '{16'h0140, 16'h0000, 16'h0103, 16'h0080,
                                    16'h01FF, 16'h0010, 16'h0110, 16'h007F,
                                    16'h007E, 16'h0105, 16'h1234, 16'hABCD};
    int p, i;
    word_ch.valid         <= 1'b0;
    word_ch.word          <= '0;
    word_ch.source_id     <= '0;
    word_ch.start_of_bank <= 1'b0;
    word_ch.words_left    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct   = 20;
    sink_stall_pct = 15;
    add_word(16'h0000, 6'd0, 1'b1, 12'd0);      // trailing padding
    add_word(16'h00F0, 6'd0, 1'b1, 12'd4095);   // empty header
    add_word(16'h05C3, 6'd21, 1'b1, 12'd2);     // count overrun
    add_word(16'hFFFF, 6'd21, 1'b0, 12'd1);     // dropped while discarding
    add_word(16'hFF32, 6'd42, 1'b1, 12'd2);     // module does not exist
    add_word(16'hFFFF, 6'd42, 1'b0, 12'd1);
    add_word(16'h0000, 6'd42, 1'b0, 12'd0);
    // unmatched fragment, short merge, full-range span, equal channels,
    // held then flushed, reversed fragments, discarded tail
    add_word(16'h05FC, 6'd63, 1'b1, 12'd12);
    for (i = 0; i < 12; i++) add_word(frag_demo[i], 6'd63, 1'b0, 12'(11 - i));
    // leave a cluster held across the mode switch
    add_word(16'h0312, 6'd5, 1'b1, 12'd2);
    add_word(16'h0045, 6'd5, 1'b0, 12'd1);
    run_plan();
    settle();

    for (p = 0; p < 7; p++) begin
      reg_write(REG_DECODE_MODE, {3'd0, phase_merge[p]});
      reg_write(REG_MAX_WIDTH, phase_width[p]);
      quiet          = (p == 6);
      send_gap_pct   = (p % 3) * 20;
      sink_stall_pct = ((p + 1) % 3) * 15;
      if (p == 0) add_word(16'h0123, 6'd5, 1'b0, 12'd0);
      while (plan_q.size() < 48) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        else add_bank();
      end
      run_plan();
      settle();
    end

    if (mismatch_total == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
